FILE: hw/rtl/isp_pkg.sv
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types, character codes and classification helpers for the streaming
// infix to postfix converter.
// ----------------------------------------------------------------------------
package isp_pkg;

    // Default sizes
    localparam int unsigned STACK_DEPTH_DEF = 32;
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // Character codes
    localparam logic [7:0] CH_POW   = 8'h5E; // '^'
    localparam logic [7:0] CH_MUL   = 8'h2A; // '*'
    localparam logic [7:0] CH_DIV   = 8'h2F; // '/'
    localparam logic [7:0] CH_ADD   = 8'h2B; // '+'
    localparam logic [7:0] CH_SUB   = 8'h2D; // '-'
    localparam logic [7:0] CH_OPEN  = 8'h28; // '('
    localparam logic [7:0] CH_CLOSE = 8'h29; // ')'
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;

    // Stack shift operation, one per cycle for the whole chain
    typedef logic [1:0] stk_op_t;
    localparam stk_op_t STK_HOLD = 2'd0;
    localparam stk_op_t STK_PUSH = 2'd1;
    localparam stk_op_t STK_POP  = 2'd2;

    // Terminator status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_UNMATCHED = 2'd3;

    // Error flag bit positions
    localparam int unsigned ERR_POS      = 0;
    localparam int unsigned ERR_OVERFLOW = 1;
    localparam int unsigned ERR_UNMATCH  = 2;

    // Precedence rank: other characters 0, '+' '-' 1, '*' '/' 2, '^' 3.
    // Order matches the signed precedence, so plain compares work.
    function automatic logic [1:0] prec_rank(input logic [7:0] c);
        logic [1:0] r;
        if (c == CH_POW) begin
            r = 2'd3;
        end else if (c == CH_MUL || c == CH_DIV) begin
            r = 2'd2;
        end else if (c == CH_ADD || c == CH_SUB) begin
            r = 2'd1;
        end else begin
            r = 2'd0;
        end
        return r;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
    endfunction

    // True when stack top t must leave before incoming operator c is pushed
    function automatic logic must_pop(input logic [7:0] t, input logic [7:0] c);
        logic [1:0] pt;
        logic [1:0] pc;
        pt = prec_rank(t);
        pc = prec_rank(c);
        return (pt > pc) || ((pt == pc) && (t != CH_POW) && (c != CH_POW));
    endfunction

endpackage

FILE: hw/rtl/isp_cell.sv
// ----------------------------------------------------------------------------
// isp_cell
// One entry of the operator stack. Takes its upper neighbour's symbol on a
// push and its lower neighbour's symbol on a pop; holds otherwise.
// ----------------------------------------------------------------------------
module isp_cell (
    input  logic             aclk,
    input  isp_pkg::stk_op_t op,
    input  logic [7:0]       from_prev,
    input  logic [7:0]       from_next,
    output logic [7:0]       data
);
    import isp_pkg::*;

    logic [7:0] data_reg;
    logic [7:0] data_next;

    // Select the shifted-in symbol
    always_comb begin
        unique case (op)
            STK_PUSH: data_next = from_prev;
            STK_POP:  data_next = from_next;
            default:  data_next = data_reg;
        endcase
    end

    // Hold the entry; payload needs no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: hw/rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Streaming shunting-yard converter: one infix character per request in,
// postfix characters out as soon as they are decided, then a terminator
// request carrying the status after the end-of-expression character.
// ----------------------------------------------------------------------------
//  Channel  Ports                                        Direction
//  s_       s_symbol, s_end_of_expr, s_valid/s_ready     in, infix characters
//  m_       m_out_symbol, m_has_symbol, m_last, m_status out, postfix characters
//           m_valid/m_ready                              and terminator
//
//  An input character is accepted, then decided, popping any stack symbols it
//  must; the end character then flushes the stack and sends the terminator. A
//  new character is taken only once the last is done. Pops run through the
//  shifting cell chain, one entry a cycle, and output stalls hold them in place.
//  Reset (aresetn low at a clock edge) empties the stack and clears counters;
//  stack cells themselves are not cleared.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
    parameter int unsigned STACK_DEPTH = isp_pkg::STACK_DEPTH_DEF,
    parameter int unsigned COUNT_WIDTH = isp_pkg::COUNT_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_symbol,
    input  logic       s_end_of_expr,
    input  logic       s_valid,
    output logic       s_ready,
    output logic [7:0] m_out_symbol,
    output logic       m_has_symbol,
    output logic       m_last,
    output logic [1:0] m_status,
    output logic       m_valid,
    input  logic       m_ready
);
    import isp_pkg::*;

    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROC  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [7:0]             sym_reg, sym_next;
    logic                   end_reg, end_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0] opnd_reg, opnd_next;
    logic [COUNT_WIDTH-1:0] oper_reg, oper_next;
    logic [COUNT_WIDTH-1:0] open_reg, open_next;
    logic [COUNT_WIDTH-1:0] close_reg, close_next;
    logic                   first_reg, first_next;
    logic [2:0]             err_reg, err_next;
    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             m_sym_reg, m_sym_next;
    logic                   m_has_reg, m_has_next;
    logic                   m_last_reg, m_last_next;
    logic [1:0]             m_status_reg, m_status_next;

    stk_op_t                stk_op;
    logic [7:0]             cell_q [STACK_DEPTH];
    logic [7:0]             top_sym;
    logic                   out_free;
    logic                   stk_empty;
    logic                   stk_full;
    logic                   invalid;
    logic                   accept;

    assign top_sym   = cell_q[0];
    assign out_free  = !m_valid_reg || m_ready;
    assign stk_empty = (cnt_reg == '0);
    assign stk_full  = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);

    // Validation checked at the end, on saturated counts
    assign invalid = err_reg[ERR_POS]
                  || ({1'b0, opnd_reg} != ({1'b0, oper_reg} + (COUNT_WIDTH + 1)'(1)))
                  || (open_reg != close_reg);

    // Operator stack: a row of shifting cells, top at index 0
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [7:0] prev_sym;
        logic [7:0] next_sym;
        if (i == 0) begin : g_top
            assign prev_sym = sym_reg;
        end else begin : g_mid
            assign prev_sym = cell_q[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_bot
            assign next_sym = cell_q[i];
        end else begin : g_up
            assign next_sym = cell_q[i+1];
        end
        isp_cell u_cell (
            .aclk      (aclk),
            .op        (stk_op),
            .from_prev (prev_sym),
            .from_next (next_sym),
            .data      (cell_q[i])
        );
    end

    // Decide the next step
    always_comb begin
        state_next    = state_reg;
        sym_next      = sym_reg;
        end_next      = end_reg;
        cnt_next      = cnt_reg;
        opnd_next     = opnd_reg;
        oper_next     = oper_reg;
        open_next     = open_reg;
        close_next    = close_reg;
        first_next    = first_reg;
        err_next      = err_reg;
        stk_op        = STK_HOLD;
        m_valid_next  = m_valid_reg && !m_ready;
        m_sym_next    = m_sym_reg;
        m_has_next    = m_has_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;

        unique case (state_reg)
            S_IDLE: begin
                // Latch the request and update the tallies
                if (accept) begin
                    sym_next   = s_symbol;
                    end_next   = s_end_of_expr;
                    first_next = 1'b0;
                    state_next = S_PROC;
                    if (is_letter(s_symbol)) begin
                        if (~&opnd_reg) opnd_next = opnd_reg + 1'b1;
                    end else if (s_symbol == CH_OPEN) begin
                        if (~&open_reg) open_next = open_reg + 1'b1;
                    end else if (s_symbol == CH_CLOSE) begin
                        if (~&close_reg) close_next = close_reg + 1'b1;
                    end else begin
                        if (~&oper_reg) oper_next = oper_reg + 1'b1;
                        if (first_reg || s_end_of_expr) err_next[ERR_POS] = 1'b1;
                    end
                end
            end

            S_PROC: begin
                priority if (is_letter(sym_reg)) begin
                    // Pass the operand straight through
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_sym_next    = sym_reg;
                        m_has_next    = 1'b1;
                        m_last_next   = 1'b0;
                        m_status_next = ST_OK;
                        state_next    = end_reg ? S_FLUSH : S_IDLE;
                    end
                end else if (sym_reg == CH_OPEN) begin
                    if (stk_full) begin
                        err_next[ERR_OVERFLOW] = 1'b1;
                    end else begin
                        stk_op   = STK_PUSH;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = end_reg ? S_FLUSH : S_IDLE;
                end else if (sym_reg == CH_CLOSE) begin
                    // Pop to the output until the matching bracket
                    if (stk_empty) begin
                        err_next[ERR_UNMATCH] = 1'b1;
                        state_next = end_reg ? S_FLUSH : S_IDLE;
                    end else if (top_sym == CH_OPEN) begin
                        stk_op     = STK_POP;
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = end_reg ? S_FLUSH : S_IDLE;
                    end else if (out_free) begin
                        stk_op        = STK_POP;
                        cnt_next      = cnt_reg - 1'b1;
                        m_valid_next  = 1'b1;
                        m_sym_next    = top_sym;
                        m_has_next    = 1'b1;
                        m_last_next   = 1'b0;
                        m_status_next = ST_OK;
                    end
                end else begin
                    // Operator: pop stronger or equal left-associative symbols, then push
                    if (!stk_empty && must_pop(top_sym, sym_reg)) begin
                        if (out_free) begin
                            stk_op        = STK_POP;
                            cnt_next      = cnt_reg - 1'b1;
                            m_valid_next  = 1'b1;
                            m_sym_next    = top_sym;
                            m_has_next    = 1'b1;
                            m_last_next   = 1'b0;
                            m_status_next = ST_OK;
                        end
                    end else begin
                        if (stk_full) begin
                            err_next[ERR_OVERFLOW] = 1'b1;
                        end else begin
                            stk_op   = STK_PUSH;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        state_next = end_reg ? S_FLUSH : S_IDLE;
                    end
                end
            end

            S_FLUSH: begin
                // Drain the stack, then send the terminator and start afresh
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (!stk_empty) begin
                        stk_op        = STK_POP;
                        cnt_next      = cnt_reg - 1'b1;
                        m_sym_next    = top_sym;
                        m_has_next    = 1'b1;
                        m_last_next   = 1'b0;
                        m_status_next = ST_OK;
                    end else begin
                        m_sym_next  = 8'd0;
                        m_has_next  = 1'b0;
                        m_last_next = 1'b1;
                        priority if (invalid) begin
                            m_status_next = ST_INVALID;
                        end else if (err_reg[ERR_OVERFLOW]) begin
                            m_status_next = ST_OVERFLOW;
                        end else if (err_reg[ERR_UNMATCH]) begin
                            m_status_next = ST_UNMATCHED;
                        end else begin
                            m_status_next = ST_OK;
                        end
                        opnd_next  = '0;
                        oper_next  = '0;
                        open_next  = '0;
                        close_next = '0;
                        first_next = 1'b1;
                        err_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            opnd_reg    <= '0;
            oper_reg    <= '0;
            open_reg    <= '0;
            close_reg   <= '0;
            first_reg   <= 1'b1;
            err_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            opnd_reg    <= opnd_next;
            oper_reg    <= oper_next;
            open_reg    <= open_next;
            close_reg   <= close_next;
            first_reg   <= first_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        sym_reg      <= sym_next;
        end_reg      <= end_next;
        m_sym_reg    <= m_sym_next;
        m_has_reg    <= m_has_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_symbol = m_sym_reg;
    assign m_has_symbol = m_has_reg;
    assign m_last       = m_last_reg;
    assign m_status     = m_status_reg;

endmodule

FILE: verif/infix_to_postfix_checker.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_checker
// Watches both channels of the converter. Every accepted infix request is run
// through a shunting-yard predictor, which queues the postfix characters and
// the terminator it must produce. Every accepted result is compared field by
// field against the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module infix_to_postfix_checker #(
    parameter int unsigned STACK_DEPTH = isp_pkg::STACK_DEPTH_DEF,
    parameter int unsigned COUNT_WIDTH = isp_pkg::COUNT_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_symbol,
    input  logic       s_end_of_expr,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] m_out_symbol,
    input  logic       m_has_symbol,
    input  logic       m_last,
    input  logic [1:0] m_status,
    input  logic       m_valid,
    input  logic       m_ready,
    output int         mismatches,
    output int         pending,
    output int         exprs_done
);
    import isp_pkg::*;

    typedef struct packed {
        logic [7:0] sym;
        logic       has_sym;
        logic       last;
        logic [1:0] status;
    } postfix_res_t;

    // Predictor state
    logic [7:0]             op_stk [STACK_DEPTH];
    int unsigned            stk_depth;
    logic [COUNT_WIDTH-1:0] n_operands;
    logic [COUNT_WIDTH-1:0] n_operators;
    logic [COUNT_WIDTH-1:0] n_opens;
    logic [COUNT_WIDTH-1:0] n_closes;
    logic                   first_pos;
    logic [2:0]             err_bits;

    // Postfix results still owed by the block, oldest first
    postfix_res_t postfix_due [$];

    initial begin
        mismatches = 0;
        pending    = 0;
        exprs_done = 0;
    end

    function automatic int rank_of(input logic [7:0] c);
        int r;
        case (c)
            CH_POW:         r = 3;
            CH_MUL, CH_DIV: r = 2;
            CH_ADD, CH_SUB: r = 1;
            default:        r = -1;
        endcase
        return r;
    endfunction

    function automatic logic alpha(input logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    endfunction

    task automatic clear_state();
        stk_depth   = 0;
        n_operands  = '0;
        n_operators = '0;
        n_opens     = '0;
        n_closes    = '0;
        first_pos   = 1'b1;
        err_bits    = '0;
    endtask

    task automatic emit(input logic [7:0] c, input logic h, input logic l,
                        input logic [1:0] st);
        postfix_due.push_back('{c, h, l, st});
    endtask

    // Saturating count
    task automatic bump(inout logic [COUNT_WIDTH-1:0] v);
        if (v != {COUNT_WIDTH{1'b1}}) v = v + 1'b1;
    endtask

    // Push, or drop and flag on a full stack
    task automatic push_stack(input logic [7:0] c);
        if (stk_depth < STACK_DEPTH) begin
            op_stk[stk_depth] = c;
            stk_depth++;
        end else begin
            err_bits[ERR_OVERFLOW] = 1'b1;
        end
    endtask

    // Predict the results of one infix request
    task automatic shunt_symbol(input logic [7:0] c, input logic eoe);
        logic [7:0]       t;
        int               pc;
        int               pt;
        logic             hit;
        logic             moving;
        logic             bad;
        logic [1:0]       st;
        logic [COUNT_WIDTH:0] ops_plus;
        if (alpha(c)) begin
            bump(n_operands);
            emit(c, 1'b1, 1'b0, ST_OK);
        end else if (c == CH_OPEN) begin
            bump(n_opens);
            push_stack(c);
        end else if (c == CH_CLOSE) begin
            bump(n_closes);
            hit = 1'b0;
            while (stk_depth > 0 && !hit) begin
                stk_depth--;
                t = op_stk[stk_depth];
                if (t == CH_OPEN) hit = 1'b1;
                else emit(t, 1'b1, 1'b0, ST_OK);
            end
            if (!hit) err_bits[ERR_UNMATCH] = 1'b1;
        end else begin
            pc = rank_of(c);
            bump(n_operators);
            if (first_pos || eoe) err_bits[ERR_POS] = 1'b1;
            moving = 1'b1;
            while (stk_depth > 0 && moving) begin
                t  = op_stk[stk_depth - 1];
                pt = rank_of(t);
                if (pt > pc || (pt == pc && t != CH_POW && c != CH_POW)) begin
                    stk_depth--;
                    emit(t, 1'b1, 1'b0, ST_OK);
                end else begin
                    moving = 1'b0;
                end
            end
            push_stack(c);
        end
        first_pos = 1'b0;

        // Flush the stack and close the expression
        if (eoe) begin
            ops_plus = {1'b0, n_operators} + 1'b1;
            bad = err_bits[ERR_POS] || ({1'b0, n_operands} != ops_plus) ||
                  (n_opens != n_closes);
            while (stk_depth > 0) begin
                stk_depth--;
                emit(op_stk[stk_depth], 1'b1, 1'b0, ST_OK);
            end
            if (bad) st = ST_INVALID;
            else if (err_bits[ERR_OVERFLOW]) st = ST_OVERFLOW;
            else if (err_bits[ERR_UNMATCH]) st = ST_UNMATCHED;
            else st = ST_OK;
            emit(8'h00, 1'b0, 1'b1, st);
            clear_state();
        end
    endtask

    task automatic note_failure(input string what, input postfix_res_t want);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected sym=%h has=%b last=%b status=%0d,",
                     $realtime, what, want.sym, want.has_sym, want.last, want.status);
            $display("    got sym=%h has=%b last=%b status=%0d",
                     m_out_symbol, m_has_symbol, m_last, m_status);
        end
    endtask

    // Compare one accepted result with the oldest one owed
    task automatic check_result();
        postfix_res_t want;
        if (postfix_due.size() == 0) begin
            note_failure("unexpected result", '0);
        end else begin
            want = postfix_due.pop_front();
            if (want.sym != m_out_symbol || want.has_sym != m_has_symbol ||
                want.last != m_last || want.status != m_status) begin
                note_failure("result mismatch", want);
            end
            if (want.last) exprs_done++;
        end
    endtask

    // Results first: nothing accepted at this edge can depend on a request
    // taken at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            postfix_due.delete();
        end else begin
            if (m_valid && m_ready) check_result();
            if (s_valid && s_ready) shunt_symbol(s_symbol, s_end_of_expr);
        end
        pending = postfix_due.size();
    end

endmodule

FILE: verif/infix_to_postfix_converter_tb.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb
// Drives infix expressions into the converter: a directed set of corner
// expressions, then random well-formed, broken and noise expressions with
// bursty requests and a stalling receiver (one long hold-off included). The
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;
    import isp_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 130;

    typedef struct packed {
        logic [7:0] sym;
        logic       eoe;
        logic       steady;
    } infix_req_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic [7:0] s_symbol      = 8'h00;
    logic       s_end_of_expr = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] m_out_symbol;
    logic       m_has_symbol;
    logic       m_last;
    logic [1:0] m_status;
    logic       m_valid;
    logic       m_ready       = 1'b0;

    int mismatches;
    int pending;
    int exprs_done;
    int accepted_reqs = 0;
    int idle_cycles   = 0;
    bit long_run      = 1'b0;

    infix_req_t stim_q [$];

    always #5 aclk = ~aclk;

    infix_to_postfix_converter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_symbol      (s_symbol),
        .s_end_of_expr (s_end_of_expr),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .m_out_symbol  (m_out_symbol),
        .m_has_symbol  (m_has_symbol),
        .m_last        (m_last),
        .m_status      (m_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

    infix_to_postfix_checker postfix_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_symbol      (s_symbol),
        .s_end_of_expr (s_end_of_expr),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .m_out_symbol  (m_out_symbol),
        .m_has_symbol  (m_has_symbol),
        .m_last        (m_last),
        .m_status      (m_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .mismatches    (mismatches),
        .pending       (pending),
        .exprs_done    (exprs_done)
    );

    task automatic push_char(input logic [7:0] c, input logic eoe, input logic steady);
        stim_q.push_back('{c, eoe, steady});
    endtask

    task automatic add_text(input string txt);
        for (int i = 0; i < txt.len(); i++) push_char(txt[i], i == txt.len() - 1, 1'b0);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = ($urandom_range(0, 1) != 0) ? CH_LC_A : CH_UC_A;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_operator();
        logic [7:0] r;
        case ($urandom_range(0, 5))
            0:       r = CH_POW;
            1:       r = CH_MUL;
            2:       r = CH_DIV;
            3:       r = CH_ADD;
            4:       r = CH_SUB;
            default: r = 8'($urandom_range(0, 255));
        endcase
        return r;
    endfunction

    // Deep expression: a chain of right-associative powers, or nested brackets
    task automatic add_deep_expr(input int n, input bit brackets);
        if (brackets) begin
            repeat (n) push_char(CH_OPEN, 1'b0, 1'b0);
            push_char(rand_letter(), 1'b0, 1'b0);
            for (int i = 0; i < n; i++) push_char(CH_CLOSE, i == n - 1, 1'b0);
        end else begin
            push_char(rand_letter(), 1'b0, 1'b0);
            for (int i = 0; i < n; i++) begin
                push_char(CH_POW, 1'b0, 1'b0);
                push_char(rand_letter(), i == n - 1, 1'b0);
            end
        end
    endtask

    // Mostly well-formed expressions, some broken by one edit, some pure noise
    task automatic add_random_expr();
        logic [7:0] tok [$];
        int         terms;
        int         depth;
        int         kind;
        int         pos;
        kind  = $urandom_range(0, 99);
        terms = $urandom_range(1, 6);
        depth = 0;
        if (kind >= 95) begin
            add_deep_expr($urandom_range(28, 36), $urandom_range(0, 1));
        end else begin
            for (int k = 0; k < terms; k++) begin
                while (depth < 4 && $urandom_range(0, 3) == 0) begin
                    tok.push_back(CH_OPEN);
                    depth++;
                end
                tok.push_back(rand_letter());
                while (depth > 0 && $urandom_range(0, 2) == 0) begin
                    tok.push_back(CH_CLOSE);
                    depth--;
                end
                if (k < terms - 1) tok.push_back(rand_operator());
            end
            while (depth > 0) begin
                tok.push_back(CH_CLOSE);
                depth--;
            end
            if (kind >= 70 && kind < 85) begin
                pos = $urandom_range(0, tok.size() - 1);
                case ($urandom_range(0, 3))
                    0: tok.delete(pos);
                    1: tok.insert(pos, rand_operator());
                    2: tok.insert(pos, CH_CLOSE);
                    default: tok[pos] = 8'($urandom_range(0, 255));
                endcase
                if (tok.size() == 0) tok.push_back(rand_letter());
            end else if (kind >= 85) begin
                tok.delete();
                repeat ($urandom_range(1, 8)) tok.push_back(8'($urandom_range(0, 255)));
            end
            for (int i = 0; i < tok.size(); i++) push_char(tok[i], i == tok.size() - 1, 1'b0);
        end
    endtask

    // Watchdog: give up when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Sender: bursts of requests with random gaps
    initial begin : stimulus
        infix_req_t req;
        int         burst_left;
        int         gap;
        int         directed_end;

        // Corner expressions: precedence, associativity, brackets, errors
        add_text("a+b*c");
        add_text("(A^B^C)");
        add_text("x/y-z");
        add_text("a)+(b");
        add_text("m");
        add_text("(a");
        push_char(8'h00, 1'b0, 1'b0);
        push_char("q", 1'b0, 1'b0);
        push_char(8'hFF, 1'b1, 1'b0);
        directed_end = stim_q.size();

        // Random part, opening with a guaranteed overflow
        add_deep_expr(33, 1'b0);
        while (stim_q.size() - directed_end < RANDOM_ITEMS) add_random_expr();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        burst_left = 0;
        while (stim_q.size() > 0) begin
            req      = stim_q.pop_front();
            long_run = req.steady;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0 || req.steady) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            s_symbol      <= req.sym;
            s_end_of_expr <= req.eoe;
            s_valid       <= 1'b1;
            do @(posedge aclk); while (!s_ready);
            accepted_reqs++;
            burst_left--;
            @(negedge aclk);
        end
        s_valid <= 1'b0;

        // Drain, then make sure nothing more turns up
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Run sent %0d infix requests forming %0d expressions,",
                 accepted_reqs, exprs_done);
        $display("with a long receiver hold-off, stack overflow, unmatched brackets and bad operator positions.");
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Receiver: phases of steady, random and sparse readiness, one long hold-off
    initial begin : sink
        int          phase_left;
        int          mode;
        logic [31:0] pat;
        bit          held;
        phase_left = 0;
        mode       = 0;
        pat        = '1;
        held       = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && !long_run && accepted_reqs >= 70) begin
                // Hold off so the block fills up and stalls its input
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (long_run) begin
                m_ready <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    mode       = $urandom_range(0, 3);
                    pat        = $urandom;
                    phase_left = 32;
                end
                phase_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= pat[phase_left];
                    2:       m_ready <= pat[phase_left] | ($urandom_range(0, 1) != 0);
                    default: m_ready <= (phase_left % 4 == 0);
                endcase
            end
        end
    end

endmodule

FILE: filelist.f
hw/rtl/isp_pkg.sv
hw/rtl/isp_cell.sv
hw/rtl/infix_to_postfix_converter.sv
verif/infix_to_postfix_checker.sv
verif/infix_to_postfix_converter_tb.sv
